[hdl/ray_box_intersection_core_defines.svh]
// Assertion macros for the ray/box intersection core checkers.
// Include with the bare file name; no other dependencies.
`ifndef RAY_BOX_INTERSECTION_CORE_DEFINES_SVH
`define RAY_BOX_INTERSECTION_CORE_DEFINES_SVH

// Check cons in the same cycle as ante.
`define RBI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define RBI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/rbi_pkg.sv]
// Shared constants and types of the ray/box intersection core.
// No dependencies.
package rbi_pkg;

  localparam int FracBits = 16;
  localparam int DataW    = 32;
  localparam int QuotW    = 31;
  localparam int RemW     = 33;
  localparam int DivSteps = 31;
  localparam int NumW     = DataW + FracBits;
  localparam int ProdW    = 64;
  localparam int NumFaces = 6;

  localparam logic [2:0] RegMinX = 3'd0;
  localparam logic [2:0] RegMinY = 3'd1;
  localparam logic [2:0] RegMinZ = 3'd2;
  localparam logic [2:0] RegMaxX = 3'd3;
  localparam logic [2:0] RegMaxY = 3'd4;
  localparam logic [2:0] RegMaxZ = 3'd5;

  typedef logic [2:0][DataW-1:0] vec3_t;

  typedef struct packed {
    vec3_t dir;
    vec3_t org;
  } ray_t;

  typedef struct packed {
    logic             pos;
    logic [DataW-1:0] nmag;
    logic [DataW-1:0] dmag;
  } face_cls_t;

  typedef struct packed {
    ray_t                           ray;
    face_cls_t [NumFaces-1:0]       face;
  } fe_item_t;

  typedef struct packed {
    logic             pos;
    logic             ovf;
    logic [RemW-1:0]  rem;
    logic [QuotW-1:0] nlo;
    logic [QuotW-1:0] q;
    logic [DataW-1:0] dmag;
  } face_div_t;

  typedef struct packed {
    logic                  pos;
    logic [QuotW-1:0]      t;
    logic [1:0][ProdW-1:0] prod;
  } face_mul_t;

  typedef struct packed {
    logic             cand;
    logic [QuotW-1:0] t;
  } cand_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

[hdl/ray_box_intersection_core.sv]
// Ray / axis-aligned box intersection core. One ray beat is taken per cycle unless the
// queue is full or the result port stalls, and one result beat leaves per ray, in
// order. Each ray passes the front register, the two-entry queue and the 31-step
// pipelined divider that forms t for all six faces in parallel, followed by a
// multiply stage, a hit-point compare stage and a two-level nearest pick. The box
// registers are written through cfg_*; write them only while no ray is in flight.
// Depends on rbi_pkg, rbi_front, rbi_fifo and rbi_back.
module ray_box_intersection_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [191:0] s_tdata,  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata,  // distance[30:0], zero pad
  output logic         m_tuser   // hit
);

  rbi_pkg::vec3_t    box_min_q, box_max_q;
  rbi_pkg::ray_t     ray;
  rbi_pkg::fe_item_t fe_item, be_item;
  logic              push, full, avail, pop, hit;
  logic [rbi_pkg::QuotW-1:0] distance;

  assign ray.org = s_tdata[95:0];
  assign ray.dir = s_tdata[191:96];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_min_q <= '0;
      box_max_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rbi_pkg::RegMinX: box_min_q[0] <= cfg_data_i;
        rbi_pkg::RegMinY: box_min_q[1] <= cfg_data_i;
        rbi_pkg::RegMinZ: box_min_q[2] <= cfg_data_i;
        rbi_pkg::RegMaxX: box_max_q[0] <= cfg_data_i;
        rbi_pkg::RegMaxY: box_max_q[1] <= cfg_data_i;
        rbi_pkg::RegMaxZ: box_max_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rbi_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_tvalid),
    .in_ready_o (s_tready),
    .ray_i      (ray),
    .box_min_i  (box_min_q),
    .box_max_i  (box_max_q),
    .push_o     (push),
    .full_i     (full),
    .item_o     (fe_item)
  );

  rbi_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i  (push),
    .full_o  (full),
    .item_i  (fe_item),
    .avail_o (avail),
    .pop_i   (pop),
    .item_o  (be_item)
  );

  rbi_back u_back (
    .clk_i, .rst_ni,
    .fifo_valid_i (avail),
    .pop_o        (pop),
    .item_i       (be_item),
    .box_min_i    (box_min_q),
    .box_max_i    (box_max_q),
    .out_valid_o  (m_tvalid),
    .out_ready_i  (m_tready),
    .hit_o        (hit),
    .dist_o       (distance)
  );

  assign m_tuser = hit;
  assign m_tdata = {1'b0, distance};

endmodule

[hdl/rbi_fifo.sv]
// Two-entry queue between the front and the back of the intersection core.
// Depends on rbi_pkg.
module rbi_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  rbi_pkg::fe_item_t item_i,
  output logic             avail_o,
  input  logic             pop_i,
  output rbi_pkg::fe_item_t item_o
);

  rbi_pkg::fe_item_t mem_q [2];
  logic              wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign avail_o = cnt_q != 2'd0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && avail_o;
  assign item_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = do_push ? !wptr_q : wptr_q;
    rptr_d = do_pop ? !rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

endmodule

[hdl/rbi_front.sv]
// Front of the intersection core: takes a ray beat and classifies its six faces.
// Depends on rbi_pkg.
module rbi_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rbi_pkg::ray_t     ray_i,
  input  rbi_pkg::vec3_t    box_min_i,
  input  rbi_pkg::vec3_t    box_max_i,
  output logic              push_o,
  input  logic              full_i,
  output rbi_pkg::fe_item_t item_o
);

  logic          v_q, v_d;
  rbi_pkg::ray_t ray_q;

  assign in_ready_o = !v_q || !full_i;
  assign push_o     = v_q;

  always_comb begin
    logic [rbi_pkg::DataW-1:0] plane;
    logic [rbi_pkg::DataW:0]   num;
    logic [rbi_pkg::DataW-1:0] dir;
    item_o.ray = ray_q;
    for (int f = 0; f < rbi_pkg::NumFaces; f++) begin
      plane = (f % 2 == 1) ? box_max_i[f/2] : box_min_i[f/2];
      dir   = ray_q.dir[f/2];
      num   = {plane[rbi_pkg::DataW-1], plane}
            - {ray_q.org[f/2][rbi_pkg::DataW-1], ray_q.org[f/2]};
      item_o.face[f].nmag = num[rbi_pkg::DataW] ? rbi_pkg::DataW'(-num)
                                                : num[rbi_pkg::DataW-1:0];
      item_o.face[f].dmag = dir[rbi_pkg::DataW-1] ? -dir : dir;
      item_o.face[f].pos  = (dir != '0) && (num != '0)
                            && (num[rbi_pkg::DataW] == dir[rbi_pkg::DataW-1]);
    end
  end

  always_comb begin
    v_d = v_q;
    if (in_valid_i && in_ready_o) begin
      v_d = 1'b1;
    end else if (v_q && !full_i) begin
      v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ray_q <= ray_i;
    end
  end

endmodule

[hdl/rbi_back.sv]
// Back of the intersection core: bit-serial pipelined divide, hit-point test, nearest pick.
// Depends on rbi_pkg.
module rbi_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fifo_valid_i,
  output logic                       pop_o,
  input  rbi_pkg::fe_item_t          item_i,
  input  rbi_pkg::vec3_t             box_min_i,
  input  rbi_pkg::vec3_t             box_max_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       hit_o,
  output logic [rbi_pkg::QuotW-1:0]  dist_o
);

  localparam int NF = rbi_pkg::NumFaces;
  localparam int DS = rbi_pkg::DivSteps;

  rbi_pkg::ray_t                  dray_q [DS+1];
  rbi_pkg::face_div_t [NF-1:0]    div_q  [DS+1];
  logic [DS:0]                    dv_q;
  rbi_pkg::ray_t                  mray_q;
  rbi_pkg::face_mul_t [NF-1:0]    mul_q;
  logic                           mv_q;
  rbi_pkg::cand_t [NF-1:0]        cmp_q;
  logic                           cv_q;
  rbi_pkg::cand_t [2:0]           red_q;
  logic                           rv_q;
  rbi_pkg::cand_t                 out_q;
  logic                           ov_q;
  logic                           en;

  rbi_pkg::face_div_t [NF-1:0]    prep;
  rbi_pkg::face_mul_t [NF-1:0]    mul_d;
  rbi_pkg::cand_t [NF-1:0]        cmp_d;
  rbi_pkg::cand_t [2:0]           red_d;
  rbi_pkg::cand_t                 out_d;

  function automatic rbi_pkg::face_div_t div_step(input rbi_pkg::face_div_t x);
    rbi_pkg::face_div_t  y;
    logic [rbi_pkg::RemW-1:0] r2;
    logic                ge;
    y  = x;
    r2 = {x.rem[rbi_pkg::RemW-2:0], x.nlo[rbi_pkg::QuotW-1]};
    ge = r2 >= {1'b0, x.dmag};
    y.rem = ge ? r2 - {1'b0, x.dmag} : r2;
    y.nlo = {x.nlo[rbi_pkg::QuotW-2:0], 1'b0};
    y.q   = {x.q[rbi_pkg::QuotW-2:0], ge};
    return y;
  endfunction

  function automatic rbi_pkg::cand_t pick(input rbi_pkg::cand_t a, input rbi_pkg::cand_t b);
    return (a.cand && (!b.cand || a.t <= b.t)) ? a : b;
  endfunction

  assign en          = !ov_q || out_ready_i;
  assign pop_o       = en;
  assign out_valid_o = ov_q;
  assign hit_o       = out_q.cand;
  assign dist_o      = out_q.cand ? out_q.t : '0;

  always_comb begin
    logic [rbi_pkg::NumW-1:0] nfull;
    for (int f = 0; f < NF; f++) begin
      nfull        = {item_i.face[f].nmag, {rbi_pkg::FracBits{1'b0}}};
      prep[f].rem  = rbi_pkg::RemW'(nfull >> rbi_pkg::QuotW);
      prep[f].ovf  = prep[f].rem >= {1'b0, item_i.face[f].dmag};
      prep[f].nlo  = nfull[rbi_pkg::QuotW-1:0];
      prep[f].q    = '0;
      prep[f].dmag = item_i.face[f].dmag;
      prep[f].pos  = item_i.face[f].pos;
    end
  end

  always_comb begin
    logic [rbi_pkg::QuotW-1:0] t;
    for (int f = 0; f < NF; f++) begin
      t = div_q[DS][f].ovf ? '1 : div_q[DS][f].q;
      mul_d[f].pos = div_q[DS][f].pos && (t != '0);
      mul_d[f].t   = t;
      for (int k = 0; k < 2; k++) begin
        mul_d[f].prod[k] = $signed({1'b0, t})
                         * $signed(dray_q[DS].dir[(f/2 + 1 + k) % 3]);
      end
    end
  end

  always_comb begin
    logic signed [rbi_pkg::ProdW-1:0] p, lo, hi;
    logic                              ok;
    int                                b;
    for (int f = 0; f < NF; f++) begin
      ok = mul_q[f].pos;
      for (int k = 0; k < 2; k++) begin
        b  = (f/2 + 1 + k) % 3;
        p  = ($signed(mul_q[f].prod[k]) >>> rbi_pkg::FracBits)
           + rbi_pkg::ProdW'($signed(mray_q.org[b]));
        lo = rbi_pkg::ProdW'($signed(box_min_i[b]));
        hi = rbi_pkg::ProdW'($signed(box_max_i[b]));
        ok = ok && (p > lo) && (p < hi);
      end
      cmp_d[f].cand = ok;
      cmp_d[f].t    = mul_q[f].t;
    end
    for (int i = 0; i < 3; i++) begin
      red_d[i] = pick(cmp_q[2*i], cmp_q[2*i+1]);
    end
    out_d = pick(pick(red_q[0], red_q[1]), red_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
      mv_q <= 1'b0;
      cv_q <= 1'b0;
      rv_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (en) begin
      dv_q <= {dv_q[DS-1:0], fifo_valid_i};
      mv_q <= dv_q[DS];
      cv_q <= mv_q;
      rv_q <= cv_q;
      ov_q <= rv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dray_q[0] <= item_i.ray;
      div_q[0]  <= prep;
      for (int i = 1; i <= DS; i++) begin
        dray_q[i] <= dray_q[i-1];
        for (int f = 0; f < NF; f++) begin
          div_q[i][f] <= div_step(div_q[i-1][f]);
        end
      end
      mray_q <= dray_q[DS];
      mul_q  <= mul_d;
      cmp_q  <= cmp_d;
      red_q  <= red_d;
      out_q  <= out_d;
    end
  end

endmodule

[hdl/rbi_checker.sv]
// Port-level checker for the ray/box intersection core, bound to the top level.
// Depends on ray_box_intersection_core_defines.svh.
`include "ray_box_intersection_core_defines.svh"

module rbi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);

  `RBI_ASSERT_NOW(a_miss_zero, m_tvalid && !m_tuser, m_tdata == 32'd0, "miss with distance")
  `RBI_ASSERT_NOW(a_hit_pos, m_tvalid && m_tuser, m_tdata != 32'd0, "hit at zero distance")
  `RBI_ASSERT_NOW(a_pad_zero, m_tvalid, !m_tdata[31], "pad bit set")
  `RBI_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid, "result beat dropped")

endmodule

bind ray_box_intersection_core rbi_checker u_rbi_checker (.*);

[tb/sv/ray_box_intersection_core_checker.sv]
// Checker for the ray/box intersection core: watches the ray and result channels,
// predicts hit and distance for each accepted ray and compares in order.
// Depends on rbi_pkg for the register indexes and FracBits.
module ray_box_intersection_core_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [191:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [31:0]  m_tdata,
  input  logic         m_tuser,
  output int           fail_count_o,
  output int           pending_o,
  output int           hit_count_o
);

  typedef struct {
    logic        hit;
    logic [30:0] distance;
  } hit_result_t;

  logic signed [63:0] box_lo [3];
  logic signed [63:0] box_hi [3];
  hit_result_t        expected_hits [$];

  function automatic logic signed [63:0] floor_q(logic signed [127:0] x);
    return 64'(x >>> rbi_pkg::FracBits);
  endfunction

  function automatic logic signed [63:0] face_t(logic signed [63:0] plane,
                                                logic signed [63:0] o,
                                                logic signed [63:0] d);
    logic signed [63:0] num;
    logic signed [63:0] q;
    num = (plane - o) * 64'sd65536;
    q = num / d;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q;
  endfunction

  function automatic bit in_slab(int b, logic signed [63:0] t,
                                 logic signed [63:0] o, logic signed [63:0] d);
    logic signed [127:0] prod;
    logic signed [63:0]  p;
    prod = 128'(t) * 128'(d);
    p = o + floor_q(prod);
    return p > box_lo[b] && p < box_hi[b];
  endfunction

  function automatic hit_result_t trace_ray(logic [191:0] ray);
    logic signed [63:0] o [3];
    logic signed [63:0] d [3];
    logic signed [63:0] t;
    logic signed [63:0] best;
    hit_result_t        r;
    bit                 found;
    int                 b;
    int                 c;
    found = 0;
    best = 0;
    for (int a = 0; a < 3; a++) begin
      o[a] = 64'(signed'(ray[32*a +: 32]));
      d[a] = 64'(signed'(ray[32*(a+3) +: 32]));
    end
    for (int a = 0; a < 3; a++) begin
      b = (a + 1) % 3;
      c = (a + 2) % 3;
      if (d[a] != 0) begin
        for (int s = 0; s < 2; s++) begin
          t = face_t(s ? box_hi[a] : box_lo[a], o[a], d[a]);
          if (t > 0 && in_slab(b, t, o[b], d[b]) && in_slab(c, t, o[c], d[c]) &&
              (!found || t < best)) begin
            found = 1;
            best = t;
          end
        end
      end
    end
    r.hit = found;
    r.distance = found ? best[30:0] : '0;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    hit_result_t exp_r;
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        box_lo[i] <= 0;
        box_hi[i] <= 0;
      end
      fail_count_o <= 0;
      hit_count_o <= 0;
      expected_hits.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rbi_pkg::RegMinX: box_lo[0] <= 64'(signed'(cfg_data_i));
          rbi_pkg::RegMinY: box_lo[1] <= 64'(signed'(cfg_data_i));
          rbi_pkg::RegMinZ: box_lo[2] <= 64'(signed'(cfg_data_i));
          rbi_pkg::RegMaxX: box_hi[0] <= 64'(signed'(cfg_data_i));
          rbi_pkg::RegMaxY: box_hi[1] <= 64'(signed'(cfg_data_i));
          rbi_pkg::RegMaxZ: box_hi[2] <= 64'(signed'(cfg_data_i));
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) expected_hits.push_back(trace_ray(s_tdata));
      if (m_tvalid && m_tready) begin
        if (expected_hits.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result beat %h/%b", m_tdata, m_tuser);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_hits.pop_front();
          if (m_tuser) hit_count_o <= hit_count_o + 1;
          if (exp_r.hit !== m_tuser || {1'b0, exp_r.distance} !== m_tdata) begin
            if (fail_count_o < 10)
              $display("mismatch: exp hit %b dist %h, got hit %b data %h",
                       exp_r.hit, exp_r.distance, m_tuser, m_tdata);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = expected_hits.size();
endmodule

[tb/sv/ray_box_intersection_core_test.sv]
// Testbench top for the ray/box intersection core: drives box registers and rays with
// random gaps and stalls; the checker module predicts and compares results.
// Depends on rbi_pkg, ray_box_intersection_core and its checker.
module ray_box_intersection_core_test;

  localparam int         CycleLimit = 400000;
  localparam int         Latency    = 60;
  localparam logic [2:0] RegUnused  = 3'd6;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [2:0]   cfg_idx_i;
  logic [31:0]  cfg_data_i;
  logic         s_tvalid;
  logic         s_tready;
  logic [191:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [31:0]  m_tdata;
  logic         m_tuser;
  int           fail_count;
  int           pending;
  int           hit_count;
  int           cycle_count;
  int           rays_sent;
  bit           calm;
  bit           long_hold;

  ray_box_intersection_core i_dut (.*);

  ray_box_intersection_core_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .s_tvalid, .s_tready,
    .s_tdata, .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .fail_count_o(fail_count), .pending_o(pending), .hit_count_o(hit_count)
  );

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    bit held;
    held = 0;
    m_tready = 0;
    @(posedge rst_ni);
    forever begin
      if (long_hold && !held) begin
        m_tready <= 0;
        repeat (300) @(posedge clk_i);
        held = 1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 0;
        n = $urandom_range(1, 16);
        repeat (n) @(posedge clk_i);
      end else begin
        m_tready <= 1;
        n = $urandom_range(1, 16);
        repeat (n) @(posedge clk_i);
      end
    end
  end

  function automatic logic [31:0] pick_q();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return $urandom;
      default: return 32'(signed'($urandom_range(0, 20 << 16)) - (10 << 16));
    endcase
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic set_box(logic [31:0] lx, logic [31:0] ly, logic [31:0] lz,
                         logic [31:0] hx, logic [31:0] hy, logic [31:0] hz);
    write_reg(rbi_pkg::RegMinX, lx);
    write_reg(rbi_pkg::RegMinY, ly);
    write_reg(rbi_pkg::RegMinZ, lz);
    write_reg(rbi_pkg::RegMaxX, hx);
    write_reg(rbi_pkg::RegMaxY, hy);
    write_reg(rbi_pkg::RegMaxZ, hz);
    write_reg(RegUnused, $urandom);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
  endtask

  task automatic send_ray(logic [191:0] ray, bit gaps);
    int n;
    if (gaps && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 0;
      n = $urandom_range(1, 16);
      repeat (n) @(posedge clk_i);
    end
    s_tvalid <= 1;
    s_tdata <= ray;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    rays_sent++;
  endtask

  function automatic logic [191:0] aimed_ray();
    logic [191:0] r;
    for (int a = 0; a < 3; a++) begin
      r[32*a +: 32] = 32'(signed'($urandom_range(0, 40 << 16)) - (20 << 16));
      r[32*(a+3) +: 32] = $urandom_range(0, 7) == 0 ? 32'h0 :
                          32'(signed'($urandom_range(0, 4 << 16)) - (2 << 16));
    end
    return r;
  endfunction

  function automatic logic [191:0] wild_ray();
    logic [191:0] r;
    for (int k = 0; k < 6; k++) r[32*k +: 32] = pick_q();
    return r;
  endfunction

  initial begin
    logic [31:0] u;
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    s_tvalid = 0;
    s_tdata = '0;
    calm = 0;
    long_hold = 0;
    rays_sent = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // reset box: degenerate, nothing counts
    send_ray(wild_ray(), 0);
    drain();
    u = 32'h0001_0000;
    set_box(-u, -u, -u, u, u, u);
    send_ray({32'h0, 32'h0, u, 32'h0, 32'h0, -(5 * u)}, 0);
    send_ray({32'h0, 32'h0, -u, 32'h0, 32'h0, 5 * u}, 0);
    send_ray({32'h0, u, 32'h0, 32'h0, -(5 * u), 32'h0}, 0);
    send_ray({u, 32'h0, 32'h0, -(5 * u), 32'h0, 32'h0}, 0);
    send_ray({32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 0);
    send_ray({32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0}, 0);
    send_ray({32'h0, 32'h0, 32'h7fff_ffff, 32'h0, 32'h0, 32'h8000_0000}, 0);
    send_ray({32'h0, 32'h0, 32'h8000_0000, 32'h0, 32'h0, 32'h7fff_ffff}, 0);
    send_ray({u, u, u, u, u, u}, 0);
    send_ray({32'h0, 32'h0, -u, 32'h0, u, 5 * u}, 0);
    for (int k = 0; k < 8; k++) send_ray(wild_ray(), 0);
    drain();
    set_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    for (int k = 0; k < 6; k++) send_ray(wild_ray(), 0);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 6) set_box(u, u, u, -u, -u, -u);
      else if (phase == 7) begin
        set_box(-(2 * u), -(3 * u), -u, 2 * u, 3 * u, u);
        calm = 1;
      end else set_box(pick_q(), pick_q(), pick_q(), pick_q(), pick_q(), pick_q());
      if (phase < 6 && phase > 0)
        set_box(-($urandom_range(1, 8 << 16)), -($urandom_range(1, 8 << 16)),
                -($urandom_range(1, 8 << 16)), $urandom_range(1, 8 << 16),
                $urandom_range(1, 8 << 16), $urandom_range(1, 8 << 16));
      if (phase == 2) long_hold = 1;
      for (int k = 0; k < 250; k++)
        send_ray($urandom_range(0, 4) == 0 ? wild_ray() : aimed_ray(), !calm);
      drain();
    end

    $display("%0d rays over directed and random boxes, %0d hits", rays_sent, hit_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("simulation failed");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+hdl
hdl/rbi_pkg.sv
hdl/rbi_fifo.sv
hdl/rbi_front.sv
hdl/rbi_back.sv
hdl/ray_box_intersection_core.sv
hdl/rbi_checker.sv
tb/sv/ray_box_intersection_core_checker.sv
tb/sv/ray_box_intersection_core_test.sv
